// File: sv/ncs_pkg.sv
// Shared types and constants for the NAND command sequencer.
package ncs_pkg;

  localparam int unsigned PAGE_BYTES  = 2048;
  localparam int unsigned BLOCK_BYTES = 131072;
  localparam int unsigned PAGE_SHIFT  = $clog2(PAGE_BYTES);

  localparam logic [2:0] REQ_READ     = 3'd0;
  localparam logic [2:0] REQ_PROG_SET = 3'd1;
  localparam logic [2:0] REQ_PROG_DAT = 3'd2;
  localparam logic [2:0] REQ_COMMIT   = 3'd3;
  localparam logic [2:0] REQ_ERASE    = 3'd4;
  localparam logic [2:0] REQ_READ_ID  = 3'd5;

  localparam logic [2:0] KIND_CMD   = 3'd0;
  localparam logic [2:0] KIND_ADDR  = 3'd1;
  localparam logic [2:0] KIND_WRITE = 3'd2;
  localparam logic [2:0] KIND_WAIT  = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;
  localparam logic [2:0] KIND_ERR   = 3'd5;

  localparam logic [7:0] CMD_READ0    = 8'h00;
  localparam logic [7:0] CMD_READ1    = 8'h30;
  localparam logic [7:0] CMD_PROG0    = 8'h80;
  localparam logic [7:0] CMD_PROG1    = 8'h10;
  localparam logic [7:0] CMD_ERASE0   = 8'h60;
  localparam logic [7:0] CMD_ERASE1   = 8'hd0;
  localparam logic [7:0] CMD_STATUS   = 8'h70;
  localparam logic [7:0] CMD_READ_ID  = 8'h90;

  typedef enum logic [2:0] {
    OP_READ,
    OP_PROG_SET,
    OP_PROG_DAT,
    OP_COMMIT,
    OP_ERASE,
    OP_ERASE_ERR,
    OP_READ_ID
  } op_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] address;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] cycle_kind;
    logic [7:0] bus_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] col;
    logic [23:0] row;
    logic [7:0]  data;
  } desc_t;

endpackage

// File: sv/ncs_front.sv
// Request decode: splits the address and classifies the request into a descriptor.
module ncs_front (
  input  ncs_pkg::in_item_t in_item,
  output logic              known,
  output ncs_pkg::desc_t    desc
);
  import ncs_pkg::*;

  logic [31:0] row_full;
  logic        aligned;

  function automatic logic [31:0] address_row(input logic [31:0] a);
    return a >> PAGE_SHIFT;
  endfunction

  assign row_full = address_row(in_item.address);
  assign aligned  = ((in_item.address & 32'(BLOCK_BYTES - 1)) == 32'd0);

  always_comb begin
    desc.col  = 16'(in_item.address & 32'(PAGE_BYTES - 1));
    desc.row  = row_full[23:0];
    desc.data = in_item.data_byte;
    desc.op   = OP_READ;
    known     = 1'b1;
    unique case (in_item.req_type)
      REQ_READ:     desc.op = OP_READ;
      REQ_PROG_SET: desc.op = OP_PROG_SET;
      REQ_PROG_DAT: desc.op = OP_PROG_DAT;
      REQ_COMMIT:   desc.op = OP_COMMIT;
      REQ_ERASE:    desc.op = aligned ? OP_ERASE : OP_ERASE_ERR;
      REQ_READ_ID:  desc.op = OP_READ_ID;
      default:      known = 1'b0;
    endcase
  end

endmodule

// File: sv/ncs_queue.sv
// Two-entry descriptor queue between decode and sequencing.
module ncs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ncs_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output ncs_pkg::desc_t head
);
  import ncs_pkg::*;

  desc_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// File: sv/ncs_back.sv
// Bus-cycle sequencer: steps through a descriptor's run into the output register.
module ncs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  ncs_pkg::desc_t    q_head,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output ncs_pkg::out_item_t out_item
);
  import ncs_pkg::*;

  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;
  out_item_t  cur;
  logic       adv;

  function automatic out_item_t gen(input desc_t d, input logic [2:0] s);
    out_item_t o;
    o.cycle_kind = KIND_CMD;
    o.bus_byte   = 8'h00;
    o.last       = 1'b0;
    unique case (d.op)
      OP_READ, OP_PROG_SET: begin
        unique case (s)
          3'd0: o.bus_byte = (d.op == OP_READ) ? CMD_READ0 : CMD_PROG0;
          3'd1: begin o.cycle_kind = KIND_ADDR; o.bus_byte = d.col[7:0]; end
          3'd2: begin o.cycle_kind = KIND_ADDR; o.bus_byte = d.col[15:8]; end
          3'd3: begin o.cycle_kind = KIND_ADDR; o.bus_byte = d.row[7:0]; end
          3'd4: begin o.cycle_kind = KIND_ADDR; o.bus_byte = d.row[15:8]; end
          3'd5: begin
            o.cycle_kind = KIND_ADDR;
            o.bus_byte   = d.row[23:16];
            o.last       = (d.op == OP_PROG_SET);
          end
          3'd6: o.bus_byte = CMD_READ1;
          default: begin o.cycle_kind = KIND_WAIT; o.last = 1'b1; end
        endcase
      end
      OP_PROG_DAT: begin
        o.cycle_kind = KIND_WRITE;
        o.bus_byte   = d.data;
        o.last       = 1'b1;
      end
      OP_COMMIT: begin
        unique case (s)
          3'd0: o.bus_byte = CMD_PROG1;
          3'd1: o.cycle_kind = KIND_WAIT;
          3'd2: o.bus_byte = CMD_STATUS;
          default: begin o.cycle_kind = KIND_READ; o.last = 1'b1; end
        endcase
      end
      OP_ERASE: begin
        unique case (s)
          3'd0: o.bus_byte = CMD_ERASE0;
          3'd1: begin o.cycle_kind = KIND_ADDR; o.bus_byte = d.row[7:0]; end
          3'd2: begin o.cycle_kind = KIND_ADDR; o.bus_byte = d.row[15:8]; end
          3'd3: begin o.cycle_kind = KIND_ADDR; o.bus_byte = d.row[23:16]; end
          3'd4: o.bus_byte = CMD_ERASE1;
          3'd5: o.cycle_kind = KIND_WAIT;
          3'd6: o.bus_byte = CMD_STATUS;
          default: begin o.cycle_kind = KIND_READ; o.last = 1'b1; end
        endcase
      end
      OP_ERASE_ERR: begin
        o.cycle_kind = KIND_ERR;
        o.last       = 1'b1;
      end
      default: begin
        unique case (s)
          3'd0: o.bus_byte = CMD_READ_ID;
          3'd1: o.cycle_kind = KIND_ADDR;
          3'd6: begin o.cycle_kind = KIND_READ; o.last = 1'b1; end
          default: o.cycle_kind = KIND_READ;
        endcase
      end
    endcase
    return o;
  endfunction

  assign cur       = gen(q_head, step_r);
  assign adv       = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    q_pop         = 1'b0;
    if (adv) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        out_item_nxt = cur;
        if (cur.last) begin
          step_nxt = 3'd0;
          q_pop    = 1'b1;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

endmodule

// File: sv/nand_command_sequencer.sv
// Top level of the large-page NAND command sequencer.
// A request is decoded as it is pushed and waits in a two-entry queue.
// The sequencer emits one bus cycle per clock unless the output stalls; run length is
// set by the request type. An idle sequencer's first bus cycle is registered in the queue,
// then in the output register. Requests stream back to back with no gap between runs.
// Synchronous active-low reset empties the queue and the output register.
module nand_command_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  ncs_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output ncs_pkg::out_item_t out_item
);
  import ncs_pkg::*;

  desc_t dec_desc;
  desc_t q_head;
  logic  dec_known;
  logic  q_empty;
  logic  q_pop;

  ncs_front u_front (
    .in_item (in_item),
    .known   (dec_known),
    .desc    (dec_desc)
  );

  ncs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push && dec_known),
    .push_desc (dec_desc),
    .full      (in_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  ncs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
